>>> rtl/core/lruk_pkg.sv
package lruk_pkg;

    localparam int unsigned FRAME_COUNT = 64;

    typedef enum logic [1:0] {
        MODE_ACCESS  = 2'd0,
        MODE_SET_EV  = 2'd1,
        MODE_REMOVE  = 2'd2,
        MODE_EVICT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ID   = 2'd2,
        ST_PINNED   = 2'd3
    } t_status;

    localparam int unsigned CFG_K_DEPTH       = 0;
    localparam int unsigned CFG_FRAMES_IN_USE = 1;
    localparam int unsigned CFG_ADDR_BITS     = 1;
    localparam int unsigned CFG_DATA_BITS     = 7;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] frame;
        logic       make_evictable;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] victim;
        logic [6:0] evictable_count;
    } t_out_item;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] frame;
        logic       make_evictable;
        logic       bad;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EXEC,
        BS_SCAN,
        BS_SCAN_TAIL,
        BS_SCAN_LAST,
        BS_OUT
    } t_back_state;

endpackage

>>> rtl/core/lruk_ram.sv
module lruk_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lruk_front.sv
module lruk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lruk_pkg::t_in_item i_item,
    input  logic [6:0]        i_frames_in_use,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output lruk_pkg::t_cmd    o_cmd
);

    lruk_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    lruk_pkg::t_cmd n_cmd;
    logic           push;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cmd.mode           = i_item.mode;
        n_cmd.frame          = i_item.frame;
        n_cmd.make_evictable = i_item.make_evictable;
        n_cmd.bad            = ({1'b0, i_item.frame} >= i_frames_in_use);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop && o_cmd_valid};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !(i_cmd_pop && o_cmd_valid))
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_cmd_pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost an entry");

endmodule

>>> rtl/core/lruk_back.sv
module lruk_back #(
    parameter int unsigned K_MAX      = 8,
    parameter int unsigned STAMP_BITS = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  lruk_pkg::t_cmd     i_cmd,
    input  logic [3:0]         i_k_depth,
    output logic               o_valid,
    input  logic               i_stall,
    output lruk_pkg::t_out_item o_item
);

    localparam int unsigned NF = lruk_pkg::FRAME_COUNT;
    localparam int unsigned FB = $clog2(NF);
    localparam int unsigned KB = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int unsigned CB = $clog2(K_MAX + 1);
    localparam int unsigned MB = CB + KB;
    localparam int unsigned EB = $clog2(NF + 1);
    localparam int unsigned AB = $clog2(NF * K_MAX);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    logic [NF-1:0]         r_tracked;
    logic [NF-1:0]         r_can_evict;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [EB-1:0]         r_ev_total;

    lruk_pkg::t_back_state r_state, n_state;
    logic [FB-1:0]         r_idx;
    logic [FB-1:0]         r_p1_idx;
    logic                  r_p1_v;
    logic [FB-1:0]         r_cand;
    logic                  r_cand_ok;
    logic                  r_cand_short;
    logic                  r_found;
    logic                  r_best_short;
    logic [FB-1:0]         r_best;
    logic [STAMP_BITS-1:0] r_best_stamp;

    logic                  r_out_valid;
    lruk_pkg::t_out_item   r_out;

    logic [CB-1:0]         k_eff;
    logic [FB-1:0]         f;
    logic                  ram_we;
    logic [AB-1:0]         ram_waddr;
    logic [AB-1:0]         ram_raddr;
    logic [STAMP_BITS-1:0] ram_rdata;
    logic                  meta_we;
    logic [MB-1:0]         meta_wdata;
    logic [FB-1:0]         meta_raddr;
    logic [MB-1:0]         meta_rdata;
    logic [FB-1:0]         m_frame;
    logic [CB-1:0]         m_cnt;
    logic [KB-1:0]         m_head;
    logic [CB-1:0]         kept;
    logic [KB-1:0]         oidx;
    logic [CB-1:0]         acc_cnt;
    logic [KB-1:0]         next_head;
    logic                  out_free;
    logic                  start;
    logic                  is_evict;
    logic                  exec;
    logic                  take;

    assign f        = i_cmd.frame[FB-1:0];
    assign out_free = !r_out_valid || !i_stall;
    assign is_evict = (i_cmd.mode == lruk_pkg::MODE_EVICT);
    assign start    = (r_state == lruk_pkg::BS_IDLE) && i_cmd_valid && out_free;
    assign exec     = (r_state == lruk_pkg::BS_EXEC);

    always_comb begin
        if (i_k_depth == 4'd0) begin
            k_eff = CB'(1);
        end else if (32'(i_k_depth) > K_MAX) begin
            k_eff = CB'(K_MAX);
        end else begin
            k_eff = CB'(i_k_depth);
        end
    end

    // Per-frame count and head are only meaningful while the frame is tracked.
    always_comb begin
        meta_raddr = (r_state == lruk_pkg::BS_SCAN) ? r_idx : f;
        m_frame = exec ? f : r_p1_idx;
        m_cnt = r_tracked[m_frame] ? meta_rdata[MB-1:KB] : '0;
        m_head = r_tracked[m_frame] ? meta_rdata[KB-1:0] : '0;
        kept = (m_cnt < k_eff) ? m_cnt : k_eff;
        oidx = KB'((32'(m_head) >= 32'(kept)) ? 32'(m_head) - 32'(kept)
                   : 32'(m_head) + K_MAX - 32'(kept));
        ram_raddr = AB'(32'(r_p1_idx) * K_MAX + 32'(oidx));
        acc_cnt = (m_cnt >= k_eff) ? k_eff - CB'(1) : m_cnt;
        next_head = (32'(m_head) == K_MAX - 1) ? '0 : m_head + KB'(1);
        ram_we = exec && !i_cmd.bad && (i_cmd.mode == lruk_pkg::MODE_ACCESS);
        ram_waddr = AB'(32'(f) * K_MAX + 32'(m_head));
        meta_we = ram_we;
        meta_wdata = {acc_cnt + CB'(1), next_head};
        take = r_cand_ok && (!r_found || (r_cand_short && !r_best_short)
               || (r_cand_short == r_best_short && ram_rdata < r_best_stamp));
    end

    lruk_ram #(.WIDTH(MB), .DEPTH(NF)) u_meta (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(f),
        .i_wdata(meta_wdata),
        .i_raddr(meta_raddr),
        .o_rdata(meta_rdata)
    );

    lruk_ram #(.WIDTH(STAMP_BITS), .DEPTH(NF * K_MAX)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_stamp),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lruk_pkg::BS_IDLE: begin
                if (start) begin
                    n_state = is_evict ? lruk_pkg::BS_SCAN : lruk_pkg::BS_EXEC;
                end
            end
            lruk_pkg::BS_EXEC: n_state = lruk_pkg::BS_IDLE;
            lruk_pkg::BS_SCAN: begin
                if (r_idx == FB'(NF - 1)) begin
                    n_state = lruk_pkg::BS_SCAN_TAIL;
                end
            end
            lruk_pkg::BS_SCAN_TAIL: n_state = lruk_pkg::BS_SCAN_LAST;
            lruk_pkg::BS_SCAN_LAST: n_state = lruk_pkg::BS_OUT;
            lruk_pkg::BS_OUT: begin
                if (out_free) begin
                    n_state = lruk_pkg::BS_IDLE;
                end
            end
            default: n_state = lruk_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = exec;
        if (r_state == lruk_pkg::BS_OUT && out_free) begin
            o_cmd_pop = 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lruk_pkg::BS_IDLE;
            r_tracked   <= '0;
            r_can_evict <= '0;
            r_stamp     <= '0;
            r_ev_total  <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_p1_v      <= 1'b0;
            r_cand_ok   <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec || (r_state == lruk_pkg::BS_OUT && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (exec) begin
                r_out.victim <= '0;
                if (i_cmd.bad) begin
                    r_out.status          <= lruk_pkg::ST_BAD_ID;
                    r_out.evictable_count <= 7'(r_ev_total);
                end else begin
                    unique case (i_cmd.mode)
                        lruk_pkg::MODE_ACCESS: begin
                            if (!r_tracked[f]) begin
                                r_tracked[f]   <= 1'b1;
                                r_can_evict[f] <= 1'b0;
                            end
                            if (r_stamp != STAMP_MAX) begin
                                r_stamp <= r_stamp + STAMP_BITS'(1);
                            end
                            r_out.status          <= lruk_pkg::ST_OK;
                            r_out.evictable_count <= 7'(r_ev_total);
                        end
                        lruk_pkg::MODE_SET_EV: begin
                            r_out.status <= lruk_pkg::ST_OK;
                            if (r_tracked[f] && r_can_evict[f] != i_cmd.make_evictable) begin
                                r_can_evict[f] <= i_cmd.make_evictable;
                                if (i_cmd.make_evictable) begin
                                    r_ev_total <= r_ev_total + EB'(1);
                                    r_out.evictable_count <= 7'(r_ev_total + EB'(1));
                                end else begin
                                    r_ev_total <= r_ev_total - EB'(1);
                                    r_out.evictable_count <= 7'(r_ev_total - EB'(1));
                                end
                            end else begin
                                r_out.evictable_count <= 7'(r_ev_total);
                            end
                        end
                        lruk_pkg::MODE_REMOVE: begin
                            if (r_tracked[f] && r_can_evict[f]) begin
                                r_tracked[f]          <= 1'b0;
                                r_can_evict[f]        <= 1'b0;
                                r_ev_total            <= r_ev_total - EB'(1);
                                r_out.status          <= lruk_pkg::ST_OK;
                                r_out.evictable_count <= 7'(r_ev_total - EB'(1));
                            end else if (r_tracked[f]) begin
                                r_out.status          <= lruk_pkg::ST_PINNED;
                                r_out.evictable_count <= 7'(r_ev_total);
                            end else begin
                                r_out.status          <= lruk_pkg::ST_OK;
                                r_out.evictable_count <= 7'(r_ev_total);
                            end
                        end
                        default: begin
                            r_out.status          <= lruk_pkg::ST_OK;
                            r_out.evictable_count <= 7'(r_ev_total);
                        end
                    endcase
                end
            end
            if (start && is_evict) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (r_state == lruk_pkg::BS_SCAN) begin
                r_idx <= r_idx + FB'(1);
            end
            r_p1_idx     <= r_idx;
            r_p1_v       <= (r_state == lruk_pkg::BS_SCAN);
            r_cand       <= r_p1_idx;
            r_cand_ok    <= r_p1_v && r_tracked[r_p1_idx] && r_can_evict[r_p1_idx];
            r_cand_short <= (m_cnt < k_eff);
            if (take) begin
                r_found      <= 1'b1;
                r_best       <= r_cand;
                r_best_short <= r_cand_short;
                r_best_stamp <= ram_rdata;
            end
            if (r_state == lruk_pkg::BS_OUT && out_free) begin
                if (r_found) begin
                    r_tracked[r_best]     <= 1'b0;
                    r_can_evict[r_best]   <= 1'b0;
                    r_ev_total            <= r_ev_total - EB'(1);
                    r_out.status          <= lruk_pkg::ST_OK;
                    r_out.victim          <= 6'(r_best);
                    r_out.evictable_count <= 7'(r_ev_total - EB'(1));
                end else begin
                    r_out.status          <= lruk_pkg::ST_EMPTY;
                    r_out.victim          <= '0;
                    r_out.evictable_count <= 7'(r_ev_total);
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ev_total) == 32'($countones(r_can_evict)))
        else $error("evictable total out of step with flags");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_can_evict & ~r_tracked) == '0)
        else $error("evictable flag on untracked frame");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lruk_pkg::BS_EXEC) |-> !ram_we)
        else $error("history write outside execution");

endmodule

>>> rtl/core/lru_k_frame_replacer.sv
// LRU-K frame replacer. Record access, set evictable and remove first read the frame's
// history count and head after acceptance, then execute. Evict scans every frame slot
// through a two-stage read of the count/head memory and the stamp memory, one frame a
// cycle. A two-entry queue sits between the input side and the execution side, so up
// to two transactions are taken while a result waits on i_stall.
module lru_k_frame_replacer #(
    parameter int unsigned K_MAX      = 8,
    parameter int unsigned STAMP_BITS = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  lruk_pkg::t_in_item                    i_item,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output lruk_pkg::t_out_item                   o_item,
    input  logic                                  i_cfg_we,
    input  logic [lruk_pkg::CFG_ADDR_BITS-1:0]    i_cfg_index,
    input  logic [lruk_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [3:0]     r_k_depth;
    logic [6:0]     r_frames_in_use;
    logic           cmd_valid;
    logic           cmd_pop;
    lruk_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_depth       <= 4'd2;
            r_frames_in_use <= 7'd64;
        end else if (i_cfg_we) begin
            if (32'(i_cfg_index) == lruk_pkg::CFG_K_DEPTH) begin
                r_k_depth <= i_cfg_data[3:0];
            end else if (32'(i_cfg_index) == lruk_pkg::CFG_FRAMES_IN_USE) begin
                r_frames_in_use <= i_cfg_data;
            end
        end
    end

    lruk_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_item         (i_item),
        .i_frames_in_use(r_frames_in_use),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_pop      (cmd_pop),
        .o_cmd          (cmd)
    );

    lruk_back #(
        .K_MAX     (K_MAX),
        .STAMP_BITS(STAMP_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_pop  (cmd_pop),
        .i_cmd      (cmd),
        .i_k_depth  (r_k_depth),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule
